// ===== sv/wto_pkg.sv =====
// wto_pkg: shared types and constants of the wavetable oscillator
// field widths, action codes, register indexes and the per-item control struct
// no dependencies
package wto_pkg;

  localparam int ACTION_BITS    = 2;
  localparam int INDEX_BITS     = 8;
  localparam int SAMPLE_BITS    = 16;
  localparam int AMP_BITS       = 16;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 1;

  // item actions
  localparam logic [ACTION_BITS-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_SWAP  = 2'd2;
  localparam logic [ACTION_BITS-1:0] ACT_STOP  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INC = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AMPLITUDE = 1'd1;

  typedef struct packed {
    logic accept;  // an item is taken this cycle
    logic tick;    // the item taken is a tick
  } item_ctl_t;

endpackage

// ===== sv/wto_if.sv =====
// wto_if: valid/ready channel interfaces of the wavetable oscillator
// depends on wto_pkg for the field widths
interface wto_in_if import wto_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic        [ACTION_BITS-1:0] action;
  logic        [INDEX_BITS-1:0]  entry_index;
  logic signed [SAMPLE_BITS-1:0] entry_value;

  modport source (output valid, action, entry_index, entry_value, input ready);
  modport sink   (input valid, action, entry_index, entry_value, output ready);
endinterface

interface wto_out_if import wto_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// ===== sv/wavetable_oscillator_interp.sv =====
// wavetable_oscillator_interp: top level of the interpolating wavetable oscillator
// depends on wto_pkg, wto_if, wto_ram, wto_ctrl and wto_interp
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    action, entry_index, entry_value
//   out_ch   out  valid/ready    sample_out (ticks only)
//   cfg_*    in   cfg_we         cfg_index, cfg_data (phase_increment, amplitude)
//
// one item per cycle while no result waits on out_ch; a tick's sample passes the ram read at
// the edge that takes it, then the gain multiply, the fraction multiply and the round/saturate
// into the output reg
// the phase and bank update in the cycle an item is taken, so any action may follow
// any other back to back; write, swap and stop give no result
// reset clears the phase, the active bank and the registers; table contents stay
// undefined until written
// while a result waits on out_ch the whole pipeline holds and in_ch.ready is low
module wavetable_oscillator_interp import wto_pkg::*; #(
  parameter int TABLE_BITS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  wto_in_if.sink                    in_ch,
  wto_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PW    = TABLE_BITS + FRAC_BITS;
  localparam int DEPTH = 2 << TABLE_BITS;   // two banks

  // configuration registers
  logic [PW-1:0]       phase_inc_r;
  logic [AMP_BITS-1:0] amplitude_r;

  item_ctl_t ctl;
  logic      advance;

  // table port wiring
  logic                          we;
  logic [TABLE_BITS:0]           waddr, raddr0, raddr1;
  logic [FRAC_BITS-1:0]          frac;
  logic [SAMPLE_BITS-1:0]        rdata0, rdata1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      amplitude_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_INC: phase_inc_r <= PW'(cfg_data);
        CFG_AMPLITUDE: amplitude_r <= cfg_data[AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = advance;
  assign ctl.accept  = in_ch.valid && advance;
  assign ctl.tick    = ctl.accept && (in_ch.action == ACT_TICK);

  wto_ctrl #(
    .TABLE_BITS (TABLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .action      (in_ch.action),
    .entry_index (in_ch.entry_index),
    .phase_inc   (phase_inc_r),
    .we          (we),
    .waddr       (waddr),
    .raddr0      (raddr0),
    .raddr1      (raddr1),
    .frac        (frac)
  );

  // two copies of the table so both neighbors are read in the same cycle
  wto_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram0 (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_ch.entry_value),
    .re    (ctl.tick),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  wto_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram1 (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_ch.entry_value),
    .re    (ctl.tick),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  wto_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .frac       (frac),
    .rdata0     ($signed(rdata0)),
    .rdata1     ($signed(rdata1)),
    .amplitude  (amplitude_r),
    .out_ready  (out_ch.ready),
    .advance    (advance),
    .out_valid  (out_ch.valid),
    .sample_out (out_ch.sample_out)
  );

endmodule

// ===== sv/wto_ram.sv =====
// wto_ram: generic single-write, single-read synchronous ram
// registered read data, held while re is low; no dependencies
module wto_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/wto_ctrl.sv =====
// wto_ctrl: phase accumulator, bank select and table address generation
// depends on wto_pkg; drives the two table rams of the top level
module wto_ctrl import wto_pkg::*; #(
  parameter int TABLE_BITS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  item_ctl_t                           ctl,
  input  logic [ACTION_BITS-1:0]              action,
  input  logic [INDEX_BITS-1:0]               entry_index,
  input  logic [TABLE_BITS+FRAC_BITS-1:0]     phase_inc,
  output logic                                we,
  output logic [TABLE_BITS:0]                 waddr,
  output logic [TABLE_BITS:0]                 raddr0,
  output logic [TABLE_BITS:0]                 raddr1,
  output logic [FRAC_BITS-1:0]                frac
);

  localparam int PW = TABLE_BITS + FRAC_BITS;

  logic [PW-1:0]         phase_r, phase_nxt;
  logic                  active_bank_r, active_bank_nxt;
  logic [TABLE_BITS-1:0] i0, i1;

  assign i0   = phase_r[PW-1 -: TABLE_BITS];
  assign i1   = i0 + 1'b1;
  assign frac = phase_r[FRAC_BITS-1:0];

  assign raddr0 = {active_bank_r, i0};
  assign raddr1 = {active_bank_r, i1};

  // writes always land in the shadow bank
  assign we    = ctl.accept && (action == ACT_WRITE);
  assign waddr = {~active_bank_r, TABLE_BITS'(entry_index)};

  always_comb begin
    phase_nxt       = phase_r;
    active_bank_nxt = active_bank_r;
    if (ctl.accept) begin
      case (action)
        ACT_TICK:  phase_nxt = phase_r + phase_inc;
        ACT_SWAP:  active_bank_nxt = ~active_bank_r;
        ACT_STOP:  phase_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= '0;
      active_bank_r <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      active_bank_r <= active_bank_nxt;
    end
  end

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept && action == ACT_STOP |=> phase_r == '0)
    else $error("phase not cleared by stop");

  a_swap_flips: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept && action == ACT_SWAP |=> active_bank_r != $past(active_bank_r))
    else $error("bank not swapped");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.accept |=> $stable(phase_r) && $stable(active_bank_r))
    else $error("state changed without an item");

endmodule

// ===== sv/wto_interp.sv =====
// wto_interp: interpolation, gain, rounding and saturation pipeline
// depends on wto_pkg; consumes the registered read data of the table rams
module wto_interp import wto_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  item_ctl_t                     ctl,
  input  logic [FRAC_BITS-1:0]          frac,
  input  logic signed [SAMPLE_BITS-1:0] rdata0,
  input  logic signed [SAMPLE_BITS-1:0] rdata1,
  input  logic [AMP_BITS-1:0]           amplitude,
  input  logic                          out_ready,
  output logic                          advance,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int AW  = 2 * SAMPLE_BITS + 1;   // s0 * amp
  localparam int DW  = 2 * SAMPLE_BITS + 2;   // (s1 - s0) * amp
  localparam int YW  = DW + FRAC_BITS + 1;    // full-precision sum
  localparam logic signed [YW-1:0] RND = YW'(1) <<< (FRAC_BITS + 14);
  localparam logic signed [YW-1:0] HI  = YW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [YW-1:0] LO  = YW'(-(1 << (SAMPLE_BITS - 1)));

  logic                          v1_r, v2_r, v3_r, out_valid_r;
  logic [FRAC_BITS-1:0]          f1_r, f2_r;
  logic signed [AW-1:0]          a0_2_r, a0_3_r;
  logic signed [DW-1:0]          ad_r;
  logic signed [YW-1:0]          p_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;

  logic signed [SAMPLE_BITS:0]   ampx, d;
  logic signed [AW-1:0]          a0;
  logic signed [DW-1:0]          ad;
  logic signed [FRAC_BITS:0]     fx;
  logic signed [YW-1:0]          p, y, q;
  logic signed [SAMPLE_BITS-1:0] sat;

  // whole pipeline moves together; freezes while a result waits
  assign advance = !out_valid_r || out_ready;

  // stage 1: difference and gain
  assign ampx = $signed({1'b0, amplitude});
  assign d    = (SAMPLE_BITS + 1)'(rdata1) - (SAMPLE_BITS + 1)'(rdata0);
  assign a0   = AW'(rdata0) * AW'(ampx);
  assign ad   = DW'(d) * DW'(ampx);

  // stage 2: fraction weight
  assign fx = $signed({1'b0, f2_r});
  assign p  = YW'(ad_r) * YW'(fx);

  // stage 3: sum, round half up, floor shift, saturate
  assign y = (YW'(a0_3_r) <<< FRAC_BITS) + p_r + RND;
  assign q = y >>> (FRAC_BITS + 15);

  always_comb begin
    if (q > HI) begin
      sat = HI[SAMPLE_BITS-1:0];
    end else if (q < LO) begin
      sat = LO[SAMPLE_BITS-1:0];
    end else begin
      sat = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= ctl.tick;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1_r     <= frac;
      f2_r     <= f1_r;
      a0_2_r   <= a0;
      ad_r     <= ad;
      a0_3_r   <= a0_2_r;
      p_r      <= p;
      sample_r <= sat;
    end
  end

  assign out_valid  = out_valid_r;
  assign sample_out = sample_r;

  a_tick_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.tick |-> advance)
    else $error("tick taken while pipeline frozen");

  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && advance |=> out_valid_r)
    else $error("finished item lost before output register");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(v3_r) && $stable(p_r) && $stable(v1_r))
    else $error("pipeline moved while frozen");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for the interpolating wavetable oscillator
// drives actions through wto_in_if, checks samples on wto_out_if against a local
// model of the phase accumulator, the two table banks and the gain stage; needs wto_pkg, wto_if
module tb_top;
  import wto_pkg::*;

  // block geometry, matched to the instance parameters
  localparam int TBL_BITS     = 8;
  localparam int FRAC_W       = 16;
  localparam int TBL_SIZE     = 1 << TBL_BITS;
  localparam int PHASE_W      = TBL_BITS + FRAC_W;
  // wait after a drain, so anything still in the pipeline has left it
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 95;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = 16'h7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = 16'h8000;
  localparam longint SAT_HI = 32767;
  localparam longint SAT_LO = -32768;

  typedef struct packed {
    logic        [ACTION_BITS-1:0] action;
    logic        [INDEX_BITS-1:0]  entry_index;
    logic signed [SAMPLE_BITS-1:0] entry_value;
  } osc_item_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // one line of the directed stimulus table
  typedef struct {
    row_kind_t                     kind;
    osc_item_t                     item;
    logic [CFG_INDEX_BITS-1:0]     reg_index;
    logic [CFG_DATA_BITS-1:0]      reg_data;
    bit                            typed;         // expected sample of a tick written in by hand
    logic signed [SAMPLE_BITS-1:0] typed_sample;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  wto_in_if  in_bus ();
  wto_out_if out_bus ();

  wavetable_oscillator_interp #(
    .TABLE_BITS(TBL_BITS),
    .FRAC_BITS (FRAC_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // local copy of the oscillator state
  logic        [PHASE_W-1:0]     osc_phase;
  logic        [PHASE_W-1:0]     osc_inc;
  logic        [AMP_BITS-1:0]    osc_amp;
  logic                          osc_bank;
  logic signed [SAMPLE_BITS-1:0] osc_table [2][TBL_SIZE];

  // samples still owed by the block, oldest first
  logic signed [SAMPLE_BITS-1:0] pending_samples [$];
  logic signed [SAMPLE_BITS-1:0] want_sample;

  int mismatch_count  = 0;
  int samples_checked = 0;
  int n_ticks         = 0;
  int n_writes        = 0;
  int n_swaps         = 0;
  int n_stops         = 0;
  int n_reg_writes    = 0;
  int cycle_count     = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // 4 time unit clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d samples outstanding",
               cycle_count, pending_samples.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic signed [SAMPLE_BITS-1:0] got,
                                 input logic signed [SAMPLE_BITS-1:0] want);
    mismatch_count++;
    $display("mismatch %0d at cycle %0d: %s, got %0d want %0d",
             mismatch_count, cycle_count, what, got, want);
  endtask

  // advance the oscillator by one item; returns 1 with the sample for a tick
  function automatic bit osc_advance(input osc_item_t it,
                                     output logic signed [SAMPLE_BITS-1:0] smp);
    logic [TBL_BITS-1:0] i0;
    logic [TBL_BITS-1:0] i1;
    longint frac, s0, s1, mix, gain, y, r;
    smp = '0;
    case (it.action)
      ACT_WRITE: begin
        // writes always land in the bank that is not playing
        osc_table[osc_bank ^ 1'b1][it.entry_index[TBL_BITS-1:0]] = it.entry_value;
        return 1'b0;
      end
      ACT_SWAP: begin
        osc_bank = osc_bank ^ 1'b1;
        return 1'b0;
      end
      ACT_STOP: begin
        osc_phase = '0;
        return 1'b0;
      end
      default: begin
        i0   = osc_phase[PHASE_W-1:FRAC_W];
        i1   = i0 + 1'b1;                      // next entry wraps around the table
        frac = longint'(osc_phase[FRAC_W-1:0]);
        s0   = longint'(osc_table[osc_bank][i0]);
        s1   = longint'(osc_table[osc_bank][i1]);
        gain = longint'(osc_amp);
        mix  = s0 * ((longint'(1) << FRAC_W) - frac) + s1 * frac;
        // single round half up over both scalings, then clamp
        y    = mix * gain + (longint'(1) << (FRAC_W + 14));
        r    = y >>> (FRAC_W + 15);
        if (r > SAT_HI) r = SAT_HI;
        if (r < SAT_LO) r = SAT_LO;
        smp  = r[SAMPLE_BITS-1:0];
        osc_phase = osc_phase + osc_inc;       // wraps modulo the table span
        return 1'b1;
      end
    endcase
  endfunction

  // offer one item, with random idle cycles ahead of it, and wait until it is taken
  task automatic send_item(input osc_item_t it, input bit typed = 1'b0,
                           input logic signed [SAMPLE_BITS-1:0] typed_sample = '0);
    logic signed [SAMPLE_BITS-1:0] predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.action      <= it.action;
    in_bus.entry_index <= it.entry_index;
    in_bus.entry_value <= it.entry_value;
    @(negedge clk);
    while (!in_bus.ready) @(negedge clk);
    // ready is settled mid-cycle, so the item goes in at the coming edge
    if (osc_advance(it, predicted))
      pending_samples.push_back(typed ? typed_sample : predicted);
    case (it.action)
      ACT_TICK:  n_ticks++;
      ACT_WRITE: n_writes++;
      ACT_SWAP:  n_swaps++;
      default:   n_stops++;
    endcase
    @(posedge clk);
  endtask

  // hold the sender off until every owed sample is back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    drain_results();
    // writes, swaps and stops may still be moving through with nothing owed
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PHASE_INC: osc_inc = data;
      CFG_AMPLITUDE: osc_amp = data[AMP_BITS-1:0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  function automatic osc_item_t make_item(input logic [ACTION_BITS-1:0] act,
                                          input logic [INDEX_BITS-1:0] idx = '0,
                                          input logic signed [SAMPLE_BITS-1:0] val = '0);
    osc_item_t it;
    it.action      = act;
    it.entry_index = idx;
    it.entry_value = val;
    return it;
  endfunction

  function automatic dir_row_t item_row(input logic [ACTION_BITS-1:0] act,
                                        input logic [INDEX_BITS-1:0] idx = '0,
                                        input logic signed [SAMPLE_BITS-1:0] val = '0);
    dir_row_t row;
    row.kind         = ROW_ITEM;
    row.item         = make_item(act, idx, val);
    row.reg_index    = CFG_PHASE_INC;
    row.reg_data     = '0;
    row.typed        = 1'b0;
    row.typed_sample = '0;
    return row;
  endfunction

  // tick whose sample is written in by hand
  function automatic dir_row_t tick_row(input logic signed [SAMPLE_BITS-1:0] want);
    dir_row_t row;
    row              = item_row(ACT_TICK);
    row.typed        = 1'b1;
    row.typed_sample = want;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                       input logic [CFG_DATA_BITS-1:0] data);
    dir_row_t row;
    row           = item_row(ACT_TICK);
    row.kind      = ROW_REG;
    row.reg_index = idx;
    row.reg_data  = data;
    return row;
  endfunction

  // fill both banks so no tick can land on an entry that was never written
  task automatic load_tables();
    repeat (2) begin
      for (int i = 0; i < TBL_SIZE; i++)
        send_item(make_item(ACT_WRITE, i[INDEX_BITS-1:0], SAMPLE_BITS'($urandom)));
      send_item(make_item(ACT_SWAP));
    end
  endtask

  // one random phase: register setting, pacing mode, then mostly playback with
  // shadow reloads, and a full drain halfway through
  task automatic run_random_phase(input int p);
    logic [CFG_DATA_BITS-1:0] inc;
    logic [CFG_DATA_BITS-1:0] amp;
    int  sent;
    int  pick;
    int  burst;
    bit  paused;
    case (p)
      0: begin inc = 24'h010000;                   amp = 24'd32768;                 end
      1: begin inc = 24'hFFFFFF;                   amp = 24'd65535;                 end
      2: begin
        inc = CFG_DATA_BITS'($urandom_range(24'h03FFFF));
        amp = CFG_DATA_BITS'($urandom_range(32768));
      end
      3: begin inc = 24'h000000;                   amp = 24'd1;                     end
      4: begin inc = CFG_DATA_BITS'($urandom);     amp = 24'd0;                     end
      5: begin
        inc = CFG_DATA_BITS'($urandom_range(24'h03FFFF));
        amp = 24'd32768;
      end
      6: begin
        inc = CFG_DATA_BITS'($urandom);
        amp = CFG_DATA_BITS'($urandom_range(16'hFFFF));
      end
      default: begin inc = 24'h000001;             amp = 24'd32767;                 end
    endcase
    write_reg(CFG_PHASE_INC, inc);
    write_reg(CFG_AMPLITUDE, amp);

    // pacing: free running, sender gaps, receiver stalls, both
    case (p % 4)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 53; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 53; end
      default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
    endcase

    sent   = 0;
    paused = 1'b0;
    while (sent < PHASE_ITEMS) begin
      if (!paused && sent >= PHASE_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        // reload part of the shadow bank, then flip to it
        burst = $urandom_range(4, 16);
        repeat (burst)
          send_item(make_item(ACT_WRITE, INDEX_BITS'($urandom), SAMPLE_BITS'($urandom)));
        send_item(make_item(ACT_SWAP));
        sent += burst + 1;
      end else begin
        if (pick < 72)
          send_item(make_item(ACT_TICK, INDEX_BITS'($urandom), SAMPLE_BITS'($urandom)));
        else if (pick < 86)
          send_item(make_item(ACT_WRITE, INDEX_BITS'($urandom), SAMPLE_BITS'($urandom)));
        else if (pick < 93)
          send_item(make_item(ACT_SWAP, INDEX_BITS'($urandom), SAMPLE_BITS'($urandom)));
        else
          send_item(make_item(ACT_STOP, INDEX_BITS'($urandom), SAMPLE_BITS'($urandom)));
        sent++;
      end
    end
  endtask

  // receiver: ready held high or dropped at random per cycle
  initial begin
    out_bus.ready = 1'b1;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker, sampled mid-cycle where the handshake is settled
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("sample with none owed", out_bus.sample_out, '0);
      end else begin
        want_sample = pending_samples.pop_front();
        if (out_bus.sample_out !== want_sample)
          report_mismatch("sample_out", out_bus.sample_out, want_sample);
        samples_checked++;
      end
    end
  end

  initial begin : stimulus
    dir_row_t rows [$];

    in_bus.valid       = 1'b0;
    in_bus.action      = ACT_TICK;
    in_bus.entry_index = '0;
    in_bus.entry_value = '0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_PHASE_INC;
    cfg_data           = '0;
    rst_n              = 1'b0;
    osc_phase          = '0;
    osc_inc            = '0;
    osc_amp            = '0;
    osc_bank           = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_tables();

    // directed part: with a zero step and unity gain a tick plays entry 0 as is
    rows.push_back(reg_row(CFG_PHASE_INC, 24'd0));
    rows.push_back(reg_row(CFG_AMPLITUDE, 24'd32768));
    rows.push_back(item_row(ACT_WRITE, 8'd0, FULL_POS));
    rows.push_back(item_row(ACT_WRITE, 8'd1, FULL_NEG));
    rows.push_back(item_row(ACT_SWAP));
    rows.push_back(tick_row(FULL_POS));
    // other bank gets the negative extreme
    rows.push_back(item_row(ACT_WRITE, 8'd0, FULL_NEG));
    rows.push_back(item_row(ACT_SWAP));
    rows.push_back(tick_row(FULL_NEG));
    // zero gain silences
    rows.push_back(reg_row(CFG_AMPLITUDE, 24'd0));
    rows.push_back(tick_row(16'sd0));
    // gain near two clamps at both ends
    rows.push_back(reg_row(CFG_AMPLITUDE, 24'd65535));
    rows.push_back(tick_row(FULL_NEG));
    rows.push_back(item_row(ACT_SWAP));
    rows.push_back(tick_row(FULL_POS));
    // half step: the midpoint between the extremes rounds up to zero
    rows.push_back(reg_row(CFG_PHASE_INC, 24'h008000));
    rows.push_back(reg_row(CFG_AMPLITUDE, 24'd32768));
    rows.push_back(tick_row(FULL_POS));
    rows.push_back(tick_row(16'sd0));
    rows.push_back(item_row(ACT_STOP));
    rows.push_back(tick_row(FULL_POS));
    // largest step: the phase overflows and the next index wraps to entry 0
    rows.push_back(reg_row(CFG_PHASE_INC, 24'hFFFFFF));
    rows.push_back(item_row(ACT_STOP));
    rows.push_back(tick_row(FULL_POS));
    rows.push_back(item_row(ACT_WRITE, 8'd255, -16'sd1));
    rows.push_back(item_row(ACT_TICK));
    rows.push_back(item_row(ACT_SWAP));
    rows.push_back(item_row(ACT_TICK));
    rows.push_back(item_row(ACT_TICK));
    rows.push_back(item_row(ACT_STOP, 8'hFF, FULL_NEG));
    rows.push_back(item_row(ACT_TICK, 8'hFF, FULL_NEG));

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_REG)
        write_reg(rows[k].reg_index, rows[k].reg_data);
      else
        send_item(rows[k].item, rows[k].typed, rows[k].typed_sample);
    end

    for (int p = 0; p < RAND_PHASES; p++)
      run_random_phase(p);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("items taken: %0d ticks, %0d table writes, %0d swaps, %0d stops",
             n_ticks, n_writes, n_swaps, n_stops);
    $display("%0d samples compared over %0d register writes and four pacing modes",
             samples_checked, n_reg_writes);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
